// ----- rtl/core/bw3_pkg.sv -----
// bw3_pkg: shared types, constants and the weight saturation helper
// for the barycentric weight pipeline. No dependencies.
package bw3_pkg;

    localparam int QB = 32;     // quotient bits resolved by each divider lane
    localparam int WW = 32;     // weight width, signed fixed point

    localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};

    typedef struct packed {
        logic vld;
        logic neg;
        logic degen;
    } t_lane_ctl;

    // Turn an unsigned quotient plus overflow flag into a saturated signed weight.
    function automatic logic signed [WW-1:0] sat_quo(input logic neg, input logic ovf,
                                                     input logic [QB-1:0] q);
        logic signed [WW-1:0] res;
        if (neg) begin
            if (ovf || (q[QB-1] && (|q[QB-2:0]))) begin
                res = WMIN;
            end else begin
                res = -$signed(q);
            end
        end else begin
            if (ovf || q[QB-1]) begin
                res = WMAX;
            end else begin
                res = $signed(q);
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/bw3_dot.sv -----
// bw3_dot: edge vectors and the five dot products, three register stages.
// Standalone; no package use.
module bw3_dot #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_a [3],
    input  logic signed [CW-1:0] i_b [3],
    input  logic signed [CW-1:0] i_c [3],
    input  logic signed [CW-1:0] i_p [3],
    output logic                 o_vld,
    output logic signed [2*CW+2:0] o_d00,
    output logic signed [2*CW+2:0] o_d01,
    output logic signed [2*CW+2:0] o_d11,
    output logic signed [2*CW+2:0] o_d20,
    output logic signed [2*CW+2:0] o_d21
);

    localparam int DW   = CW + 1;
    localparam int PPW  = 2 * DW;
    localparam int DOTW = 2 * CW + 3;

    logic [2:0]            r_vld;
    logic signed [DW-1:0]  r_e0 [3];
    logic signed [DW-1:0]  r_e1 [3];
    logic signed [DW-1:0]  r_q  [3];
    logic signed [PPW-1:0] r_m  [5][3];
    logic signed [DOTW-1:0] r_d [5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e0[k] <= DW'(i_b[k]) - DW'(i_a[k]);
            r_e1[k] <= DW'(i_c[k]) - DW'(i_a[k]);
            r_q[k]  <= DW'(i_p[k]) - DW'(i_a[k]);
            r_m[0][k] <= r_e0[k] * r_e0[k];
            r_m[1][k] <= r_e0[k] * r_e1[k];
            r_m[2][k] <= r_e1[k] * r_e1[k];
            r_m[3][k] <= r_q[k] * r_e0[k];
            r_m[4][k] <= r_q[k] * r_e1[k];
        end
        for (int j = 0; j < 5; j++) begin
            r_d[j] <= DOTW'(r_m[j][0]) + DOTW'(r_m[j][1]) + DOTW'(r_m[j][2]);
        end
    end

    assign o_vld = r_vld[2];
    assign o_d00 = r_d[0];
    assign o_d01 = r_d[1];
    assign o_d11 = r_d[2];
    assign o_d20 = r_d[3];
    assign o_d21 = r_d[4];

endmodule

// ----- rtl/core/bw3_wmul.sv -----
// bw3_wmul: signed wide multiplier, split into four half-width partial
// products (stage A) and a summing stage (stage B). No dependencies.
module bw3_wmul #(
    parameter int OW = 35
) (
    input  logic                   i_clk,
    input  logic signed [OW-1:0]   i_a,
    input  logic signed [OW-1:0]   i_b,
    output logic signed [2*OW-1:0] o_p
);

    localparam int H  = (OW + 1) / 2;
    localparam int PW = 2 * OW;
    localparam int SW = 4 * H;

    logic [2*H-1:0] ma;
    logic [2*H-1:0] mb;
    logic [SW-1:0]  sum;
    logic [PW-1:0]  mag;

    logic [2*H-1:0] r_ll, r_lh, r_hl, r_hh;
    logic           r_neg;
    logic signed [PW-1:0] r_p;

    always_comb begin
        ma  = (2*H)'($unsigned(i_a[OW-1] ? -i_a : i_a));
        mb  = (2*H)'($unsigned(i_b[OW-1] ? -i_b : i_b));
        sum = SW'(r_ll) + ((SW'(r_lh) + SW'(r_hl)) << H) + (SW'(r_hh) << (2*H));
        mag = sum[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_ll  <= ma[H-1:0]   * mb[H-1:0];
        r_lh  <= ma[H-1:0]   * mb[2*H-1:H];
        r_hl  <= ma[2*H-1:H] * mb[H-1:0];
        r_hh  <= ma[2*H-1:H] * mb[2*H-1:H];
        r_neg <= i_a[OW-1] ^ i_b[OW-1];
        r_p   <= r_neg ? -$signed(mag) : $signed(mag);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/bw3_div.sv -----
// bw3_div: one divider lane, an overflow check stage then one restoring
// step per quotient bit, fully pipelined. Uses bw3_pkg.
module bw3_div
    import bw3_pkg::*;
#(
    parameter int DDW = 71,
    parameter int NW  = 87
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_lane_ctl       i_ctl,
    input  logic [NW-1:0]   i_num,
    input  logic [DDW-1:0]  i_den,
    output t_lane_ctl       o_ctl,
    output logic            o_ovf,
    output logic [QB-1:0]   o_quo
);

    localparam int CMPW = DDW + QB;

    t_lane_ctl        r_ctl [QB+1];
    logic [CMPW-1:0]  r_rem [QB+1];
    logic [DDW-1:0]   r_den [QB+1];
    logic [QB-1:0]    r_quo [QB+1];
    logic             r_ovf [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    // quotient would need more than QB bits
    always_ff @(posedge i_clk) begin
        r_rem[0] <= CMPW'(i_num);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_ovf[0] <= CMPW'(i_num) >= {i_den, {QB{1'b0}}};
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
        localparam int SH = QB - 1 - s;
        logic [CMPW:0] diff;

        assign diff = {1'b0, r_rem[s]} - {1'b0, CMPW'(r_den[s]) << SH};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s+1] <= '0;
            end else begin
                r_ctl[s+1] <= r_ctl[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            r_ovf[s+1] <= r_ovf[s];
            if (!diff[CMPW]) begin
                r_rem[s+1] <= diff[CMPW-1:0];
                r_quo[s+1] <= {r_quo[s][QB-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= r_rem[s];
                r_quo[s+1] <= {r_quo[s][QB-2:0], 1'b0};
            end
        end
    end

    assign o_ctl = r_ctl[QB];
    assign o_ovf = r_ovf[QB];
    assign o_quo = r_quo[QB];

endmodule

// ----- rtl/core/barycentric_weights_3d_top.sv -----
// barycentric_weights_3d_top: barycentric weights of a point against a 3D
// triangle. Depends on bw3_pkg, bw3_dot, bw3_wmul, bw3_div.
//
// Usage:
//   Drive the twelve corner and point coordinates and pulse start. A beat is
//   taken at every edge where start is high and busy is low; busy is held
//   low, so one beat per cycle is accepted with no gaps.
//   Each beat yields one result: o_valid is high for
//   one cycle with o_weight_u/v/w (signed, WEIGHT_FRAC_BITS fraction bits,
//   saturated) and o_degenerate.
//   The divider lanes make up most of the pipeline, one quotient bit per stage over 32
//   stages plus an overflow check; the front end (differences, dot products,
//   split multipliers, numerators) precedes them and two output stages follow.
//   Throughput is one beat per cycle.
//   A degenerate triangle (zero denominator) raises o_degenerate with zero
//   weights.
//   Reset clears all valid bits; beats in flight are dropped. Results cannot
//   be held off by the receiver, so the pipeline never stalls.
module barycentric_weights_3d_top
    import bw3_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_corner_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_corner_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_corner_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner_c_z,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                          o_valid,
    output logic signed [WW-1:0]          o_weight_u,
    output logic signed [WW-1:0]          o_weight_v,
    output logic signed [WW-1:0]          o_weight_w,
    output logic                          o_degenerate
);

    localparam int DOTW = 2 * COORD_WIDTH + 3;
    localparam int PW   = 2 * DOTW;
    localparam int DDW  = PW + 1;
    localparam int NW   = DDW + WEIGHT_FRAC_BITS;
    localparam int UW   = WW + 2;
    localparam int LAT  = QB + 10;
    localparam logic signed [UW-1:0] WONE = UW'(1 << WEIGHT_FRAC_BITS);

    logic signed [COORD_WIDTH-1:0] ca [3];
    logic signed [COORD_WIDTH-1:0] cb [3];
    logic signed [COORD_WIDTH-1:0] cc [3];
    logic signed [COORD_WIDTH-1:0] cp [3];

    logic                   dvld;
    logic signed [DOTW-1:0] d00, d01, d11, d20, d21;
    logic signed [PW-1:0]   p00_11, p01_01, p11_20, p01_21, p00_21, p01_20;

    logic [1:0]             r_mvld;
    logic                   r_nvld;
    logic signed [DDW-1:0]  r_den, r_nv, r_nw;
    t_lane_ctl              r_ctl_v, r_ctl_w;
    logic [NW-1:0]          r_num_v, r_num_w;
    logic [DDW-1:0]         r_dmag;

    t_lane_ctl              ctl_v, ctl_w;
    logic                   ovf_v, ovf_w;
    logic [QB-1:0]          quo_v, quo_w;

    logic                   r_svld, r_sdeg;
    logic signed [WW-1:0]   r_sv, r_sw;
    logic                   r_ovld, r_odeg;
    logic signed [WW-1:0]   r_wu, r_wv, r_ww;

    logic signed [UW-1:0]   u_sum;
    logic signed [WW-1:0]   u_sat;
    logic [DDW-1:0]         nv_mag, nw_mag, den_mag;

    assign ca[0] = i_corner_a_x;  assign ca[1] = i_corner_a_y;  assign ca[2] = i_corner_a_z;
    assign cb[0] = i_corner_b_x;  assign cb[1] = i_corner_b_y;  assign cb[2] = i_corner_b_z;
    assign cc[0] = i_corner_c_x;  assign cc[1] = i_corner_c_y;  assign cc[2] = i_corner_c_z;
    assign cp[0] = i_point_x;     assign cp[1] = i_point_y;     assign cp[2] = i_point_z;

    assign busy = 1'b0;

    bw3_dot #(.CW(COORD_WIDTH)) u_dot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (start && !busy),
        .i_a    (ca),
        .i_b    (cb),
        .i_c    (cc),
        .i_p    (cp),
        .o_vld  (dvld),
        .o_d00  (d00),
        .o_d01  (d01),
        .o_d11  (d11),
        .o_d20  (d20),
        .o_d21  (d21)
    );

    bw3_wmul #(.OW(DOTW)) u_m0 (.i_clk(i_clk), .i_a(d00), .i_b(d11), .o_p(p00_11));
    bw3_wmul #(.OW(DOTW)) u_m1 (.i_clk(i_clk), .i_a(d01), .i_b(d01), .o_p(p01_01));
    bw3_wmul #(.OW(DOTW)) u_m2 (.i_clk(i_clk), .i_a(d11), .i_b(d20), .o_p(p11_20));
    bw3_wmul #(.OW(DOTW)) u_m3 (.i_clk(i_clk), .i_a(d01), .i_b(d21), .o_p(p01_21));
    bw3_wmul #(.OW(DOTW)) u_m4 (.i_clk(i_clk), .i_a(d00), .i_b(d21), .o_p(p00_21));
    bw3_wmul #(.OW(DOTW)) u_m5 (.i_clk(i_clk), .i_a(d01), .i_b(d20), .o_p(p01_20));

    always_comb begin
        nv_mag  = $unsigned(r_nv[DDW-1] ? -r_nv : r_nv);
        nw_mag  = $unsigned(r_nw[DDW-1] ? -r_nw : r_nw);
        den_mag = $unsigned(r_den[DDW-1] ? -r_den : r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld  <= '0;
            r_nvld  <= 1'b0;
            r_ctl_v <= '0;
            r_ctl_w <= '0;
            r_svld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_mvld  <= {r_mvld[0], dvld};
            r_nvld  <= r_mvld[1];
            r_ctl_v <= '{vld: r_nvld, neg: r_nv[DDW-1] ^ r_den[DDW-1], degen: r_den == '0};
            r_ctl_w <= '{vld: r_nvld, neg: r_nw[DDW-1] ^ r_den[DDW-1], degen: r_den == '0};
            r_svld  <= ctl_v.vld;
            r_ovld  <= r_svld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den   <= DDW'(p00_11) - DDW'(p01_01);
        r_nv    <= DDW'(p11_20) - DDW'(p01_21);
        r_nw    <= DDW'(p00_21) - DDW'(p01_20);
        r_num_v <= NW'(nv_mag) << WEIGHT_FRAC_BITS;
        r_num_w <= NW'(nw_mag) << WEIGHT_FRAC_BITS;
        r_dmag  <= den_mag;
    end

    bw3_div #(.DDW(DDW), .NW(NW)) u_div_v (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_ctl_v),
        .i_num  (r_num_v),
        .i_den  (r_dmag),
        .o_ctl  (ctl_v),
        .o_ovf  (ovf_v),
        .o_quo  (quo_v)
    );

    bw3_div #(.DDW(DDW), .NW(NW)) u_div_w (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_ctl_w),
        .i_num  (r_num_w),
        .i_den  (r_dmag),
        .o_ctl  (ctl_w),
        .o_ovf  (ovf_w),
        .o_quo  (quo_w)
    );

    always_ff @(posedge i_clk) begin
        r_sdeg <= ctl_v.degen;
        r_sv   <= sat_quo(ctl_v.neg, ovf_v, quo_v);
        r_sw   <= sat_quo(ctl_w.neg, ovf_w, quo_w);
    end

    // u = 1 - v - w, clamped back to the weight range
    always_comb begin
        u_sum = WONE - UW'(r_sv) - UW'(r_sw);
        if (u_sum[UW-1] && !(&u_sum[UW-2:WW-1])) begin
            u_sat = WMIN;
        end else if (!u_sum[UW-1] && (|u_sum[UW-2:WW-1])) begin
            u_sat = WMAX;
        end else begin
            u_sat = u_sum[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_odeg <= r_sdeg;
        r_wu   <= r_sdeg ? '0 : u_sat;
        r_wv   <= r_sdeg ? '0 : r_sv;
        r_ww   <= r_sdeg ? '0 : r_sw;
    end

    assign o_valid      = r_ovld;
    assign o_degenerate = r_odeg;
    assign o_weight_u   = r_wu;
    assign o_weight_v   = r_wv;
    assign o_weight_w   = r_ww;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after accepted beat");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching beat");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_weight_u == '0 && o_weight_v == '0 && o_weight_w == '0))
        else $error("degenerate result with nonzero weights");

    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_v.vld == ctl_w.vld && (!ctl_v.vld || ctl_v.degen == ctl_w.degen))
        else $error("divider lanes out of step");

endmodule
